[src/ssc_pkg.sv]
`timescale 1ns / 1ps

package ssc_pkg;

    localparam int COLUMNS       = 64;
    localparam int MAX_ROWS      = 256;
    localparam int CAPACITY      = 1024;
    localparam int MIN_ROW_COUNT = 1;
    localparam int DEFAULT_ROWS  = 64;

    localparam int FUNC_W  = 2;
    localparam int COL_W   = 6;
    localparam int COLX_W  = COL_W + 1;
    localparam int ROW_W   = 9;
    localparam int BYTE_W  = 8;
    localparam int STAT_W  = 2;
    localparam int USED_W  = 11;
    localparam int KEY_W   = (COLUMNS * MAX_ROWS > 1) ? $clog2(COLUMNS * MAX_ROWS) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);

    localparam logic [FUNC_W-1:0] FN_READ   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_WRITE  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_SETLEN = 2'd2;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic              erase;
        logic [BYTE_W-1:0] note_value;
        logic [BYTE_W-1:0] instrument_value;
        logic [BYTE_W-1:0] volume_value;
        logic [BYTE_W-1:0] command_value;
        logic [BYTE_W-1:0] argument_value;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              found;
        logic [BYTE_W-1:0] note_out;
        logic [BYTE_W-1:0] instrument_out;
        logic [BYTE_W-1:0] volume_out;
        logic [BYTE_W-1:0] command_out;
        logic [BYTE_W-1:0] argument_out;
        logic [USED_W-1:0] entries_used;
        logic [ROW_W-1:0]  rows_now;
    } t_out;

    typedef struct packed {
        logic [BYTE_W-1:0] note;
        logic [BYTE_W-1:0] instrument;
        logic [BYTE_W-1:0] volume;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] argument;
    } t_data;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        t_data            data;
    } t_entry;

endpackage

[src/ssc_cell.sv]
`timescale 1ns / 1ps

module ssc_cell (
    input  logic            i_clk,
    input  logic            i_en,
    input  ssc_pkg::t_entry i_d,
    output ssc_pkg::t_entry o_q
);

    ssc_pkg::t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

[src/sparse_sorted_cell_store.sv]
`timescale 1ns / 1ps

// Sorted sparse cell table held in a ring of CAPACITY cells. Reads, writes and erases
// of a valid cell, and a set-length that shrinks the row count, rotate the whole ring
// once, one entry per cycle past the comparator at the head; clear, bad coordinates
// and other set-length requests skip the rotation and go straight to the result. A new
// input is accepted once the previous result has been loaded into the output register,
// even while that result still waits there to be taken. No clearing pass is needed
// after reset.
module sparse_sorted_cell_store (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ssc_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ssc_pkg::t_out o_out_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PASS = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [1:0] MD_NORM  = 2'd0;
    localparam logic [1:0] MD_AHEAD = 2'd1;
    localparam logic [1:0] MD_DELAY = 2'd2;

    logic [1:0]                  r_state, n_state;
    ssc_pkg::t_in                r_item, n_item;
    logic [ssc_pkg::KEY_W-1:0]   r_key, n_key;
    logic [ssc_pkg::CNT_W-1:0]   r_step, n_step;
    logic                        r_trig, n_trig;
    logic [1:0]                  r_mode, n_mode;
    ssc_pkg::t_entry             r_carry;
    logic [ssc_pkg::CNT_W-1:0]   r_count, n_count;
    logic [ssc_pkg::CNT_W-1:0]   r_new_count, n_new_count;
    logic [ssc_pkg::ROW_W-1:0]   r_rows, n_rows;
    logic [ssc_pkg::STAT_W-1:0]  r_status, n_status;
    logic                        r_found, n_found;
    ssc_pkg::t_data              r_rdata, n_rdata;
    ssc_pkg::t_out               r_out, n_out;
    logic                        r_ovalid, n_ovalid;

    ssc_pkg::t_entry w_cell [ssc_pkg::CAPACITY];
    ssc_pkg::t_entry w_head;
    ssc_pkg::t_entry w_next;
    ssc_pkg::t_entry w_push;
    ssc_pkg::t_entry w_new;
    logic            w_shift;
    logic            w_in_range;
    logic            w_lt;
    logic            w_trig;
    logic            w_hit;

    genvar g;
    generate
        for (g = 0; g < ssc_pkg::CAPACITY; g++) begin : g_ring
            if (g == ssc_pkg::CAPACITY - 1) begin : g_tail
                ssc_cell u_cell (
                    .i_clk (i_clk),
                    .i_en  (w_shift),
                    .i_d   (w_push),
                    .o_q   (w_cell[g])
                );
            end else begin : g_body
                ssc_cell u_cell (
                    .i_clk (i_clk),
                    .i_en  (w_shift),
                    .i_d   (w_cell[g+1]),
                    .o_q   (w_cell[g])
                );
            end
        end
        if (ssc_pkg::CAPACITY > 1) begin : g_next_cell
            assign w_next = w_cell[1];
        end else begin : g_next_head
            assign w_next = w_cell[0];
        end
    endgenerate

    assign w_head     = w_cell[0];
    assign w_shift    = (r_state == S_PASS);
    assign w_in_range = (r_step < r_count);
    assign w_lt       = w_in_range && (w_head.key < r_key);
    assign w_trig     = w_shift && !r_trig && !w_lt;
    assign w_hit      = w_trig && w_in_range && (w_head.key == r_key);

    always_comb begin
        w_new.key             = r_key;
        w_new.data.note       = r_item.note_value;
        w_new.data.instrument = r_item.instrument_value;
        w_new.data.volume     = r_item.volume_value;
        w_new.data.command    = r_item.command_value;
        w_new.data.argument   = r_item.argument_value;
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_key       = r_key;
        n_step      = r_step;
        n_trig      = r_trig;
        n_mode      = r_mode;
        n_count     = r_count;
        n_new_count = r_new_count;
        n_rows      = r_rows;
        n_status    = r_status;
        n_found     = r_found;
        n_rdata     = r_rdata;
        n_out       = r_out;
        n_ovalid    = r_ovalid && !i_out_ready;

        case (r_mode)
            MD_AHEAD: w_push = w_next;
            MD_DELAY: w_push = r_carry;
            default:  w_push = w_head;
        endcase

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item      = i_in_data;
                    n_status    = ssc_pkg::STAT_OK;
                    n_found     = 1'b0;
                    n_rdata     = '0;
                    n_step      = '0;
                    n_trig      = 1'b0;
                    n_mode      = MD_NORM;
                    n_new_count = r_count;
                    n_state     = S_DONE;
                    unique case (i_in_data.func) inside
                        ssc_pkg::FN_READ, ssc_pkg::FN_WRITE: begin
                            if (({1'b0, i_in_data.column} >=
                                 ssc_pkg::COLX_W'(ssc_pkg::COLUMNS)) ||
                                (i_in_data.row >= r_rows)) begin
                                n_status = ssc_pkg::STAT_RANGE;
                            end else begin
                                n_key   = ssc_pkg::KEY_W'(int'(i_in_data.row) * ssc_pkg::COLUMNS
                                                          + int'(i_in_data.column));
                                n_state = S_PASS;
                                if ((i_in_data.func == ssc_pkg::FN_WRITE) &&
                                    !i_in_data.erase) begin
                                    n_status = ssc_pkg::STAT_FULL;
                                end
                            end
                        end
                        ssc_pkg::FN_SETLEN: begin
                            if (i_in_data.row > ssc_pkg::ROW_W'(ssc_pkg::MAX_ROWS)) begin
                                n_status = ssc_pkg::STAT_RANGE;
                            end else if (i_in_data.row >=
                                         ssc_pkg::ROW_W'(ssc_pkg::MIN_ROW_COUNT)) begin
                                n_rows = i_in_data.row;
                                if (i_in_data.row < r_rows) begin
                                    n_key   = ssc_pkg::KEY_W'(int'(i_in_data.row)
                                                              * ssc_pkg::COLUMNS);
                                    n_state = S_PASS;
                                end
                            end
                        end
                        ssc_pkg::FN_CLEAR: begin
                            n_count = '0;
                            n_rows  = ssc_pkg::ROW_W'(ssc_pkg::DEFAULT_ROWS);
                        end
                        default: ;
                    endcase
                end
            end
            S_PASS: begin
                n_step = r_step + 1'b1;
                if (w_trig) begin
                    n_trig = 1'b1;
                    unique case (r_item.func)
                        ssc_pkg::FN_READ: begin
                            if (w_hit) begin
                                n_found = 1'b1;
                                n_rdata = w_head.data;
                            end
                        end
                        ssc_pkg::FN_WRITE: begin
                            if (r_item.erase) begin
                                if (w_hit) begin
                                    w_push      = w_next;
                                    n_mode      = MD_AHEAD;
                                    n_new_count = r_count - 1'b1;
                                end
                            end else if (w_hit) begin
                                w_push   = w_new;
                                n_status = ssc_pkg::STAT_OK;
                            end else if (r_count < ssc_pkg::CNT_W'(ssc_pkg::CAPACITY)) begin
                                w_push      = w_new;
                                n_mode      = MD_DELAY;
                                n_new_count = r_count + 1'b1;
                                n_status    = ssc_pkg::STAT_OK;
                            end
                        end
                        default: begin
                            n_new_count = r_step;
                        end
                    endcase
                end
                if (r_step == ssc_pkg::CNT_W'(ssc_pkg::CAPACITY - 1)) begin
                    n_count = n_new_count;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_out.status         = r_status;
                    n_out.found          = r_found;
                    n_out.note_out       = r_rdata.note;
                    n_out.instrument_out = r_rdata.instrument;
                    n_out.volume_out     = r_rdata.volume;
                    n_out.command_out    = r_rdata.command;
                    n_out.argument_out   = r_rdata.argument;
                    n_out.entries_used   = ssc_pkg::USED_W'(r_count);
                    n_out.rows_now       = r_rows;
                    n_ovalid             = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_count  <= '0;
            r_rows   <= ssc_pkg::ROW_W'(ssc_pkg::DEFAULT_ROWS);
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_count  <= n_count;
            r_rows   <= n_rows;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_key       <= n_key;
        r_step      <= n_step;
        r_trig      <= n_trig;
        r_mode      <= n_mode;
        r_new_count <= n_new_count;
        r_status    <= n_status;
        r_found     <= n_found;
        r_rdata     <= n_rdata;
        r_out       <= n_out;
        if (w_shift) begin
            r_carry <= w_head;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

[src/ssc_checker.sv]
`timescale 1ns / 1ps

module ssc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input ssc_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input ssc_pkg::t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("Result changed or dropped while the transfer was stalled.");

    a_used_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.entries_used <= ssc_pkg::USED_W'(ssc_pkg::CAPACITY))
        else $error("Entry count exceeds the table capacity.");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.found |-> o_out_data.status == ssc_pkg::STAT_OK)
        else $error("A found cell was reported with an error status.");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |->
            o_out_data.note_out == '0 && o_out_data.instrument_out == '0 &&
            o_out_data.volume_out == '0 && o_out_data.command_out == '0 &&
            o_out_data.argument_out == '0)
        else $error("Cell bytes are nonzero on a result without a found cell.");

    a_rows_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_out_data.rows_now >= ssc_pkg::ROW_W'(ssc_pkg::MIN_ROW_COUNT) &&
            o_out_data.rows_now <= ssc_pkg::ROW_W'(ssc_pkg::MAX_ROWS))
        else $error("Row count is outside its legal range.");

endmodule

bind sparse_sorted_cell_store ssc_checker u_ssc_checker (.*);

[bench/tb_sparse_sorted_cell_store.sv]
`timescale 1ns / 1ps

module tb_sparse_sorted_cell_store;
    import ssc_pkg::*;

    localparam int CYCLE_LIMIT = 15_000_000;
    localparam int DRAIN_CYCLES = 2 * (CAPACITY + 2);
    localparam int HOLD_OFF_CYCLES = 4000;
    localparam int RANDOM_OPS = 550;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    t_in i_in_data = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    sparse_sorted_cell_store dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the sorted table.
    logic [KEY_W-1:0] tbl_key [CAPACITY];
    t_data tbl_data [CAPACITY];
    int tbl_count = 0;
    int tbl_rows = DEFAULT_ROWS;

    t_in op_queue[$];
    t_out expected_q[$];
    int recent_cells[$];

    int error_count = 0;
    int results_seen = 0;
    int cycles = 0;

    function automatic int find_slot(int k);
        int lo, hi, mid;
        lo = 0;
        hi = tbl_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (int'(tbl_key[mid]) < k) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    function automatic t_out apply_cell_op(t_in op);
        t_out r;
        t_data wv;
        int k, s, i;
        logic hit;
        r = '0;
        wv = {op.note_value, op.instrument_value, op.volume_value,
              op.command_value, op.argument_value};
        case (op.func) inside
            FN_READ, FN_WRITE: begin
                if (int'(op.column) >= COLUMNS || int'(op.row) >= tbl_rows) begin
                    r.status = STAT_RANGE;
                end else begin
                    k = int'(op.row) * COLUMNS + int'(op.column);
                    s = find_slot(k);
                    hit = (s < tbl_count) && (int'(tbl_key[s]) == k);
                    if (op.func == FN_READ) begin
                        if (hit) begin
                            r.found = 1'b1;
                            {r.note_out, r.instrument_out, r.volume_out,
                             r.command_out, r.argument_out} = tbl_data[s];
                        end
                    end else if (op.erase) begin
                        if (hit) begin
                            for (i = s; i < tbl_count - 1; i++) begin
                                tbl_key[i] = tbl_key[i + 1];
                                tbl_data[i] = tbl_data[i + 1];
                            end
                            tbl_count--;
                        end
                    end else if (hit) begin
                        tbl_data[s] = wv;
                    end else if (tbl_count >= CAPACITY) begin
                        r.status = STAT_FULL;
                    end else begin
                        for (i = tbl_count; i > s; i--) begin
                            tbl_key[i] = tbl_key[i - 1];
                            tbl_data[i] = tbl_data[i - 1];
                        end
                        tbl_key[s] = KEY_W'(k);
                        tbl_data[s] = wv;
                        tbl_count++;
                    end
                end
            end
            FN_SETLEN: begin
                if (int'(op.row) > MAX_ROWS) begin
                    r.status = STAT_RANGE;
                end else if (int'(op.row) >= MIN_ROW_COUNT) begin
                    if (int'(op.row) < tbl_rows) begin
                        tbl_count = find_slot(int'(op.row) * COLUMNS);
                    end
                    tbl_rows = int'(op.row);
                end
            end
            default: begin
                tbl_count = 0;
                tbl_rows = DEFAULT_ROWS;
            end
        endcase
        r.entries_used = USED_W'(tbl_count);
        r.rows_now = ROW_W'(tbl_rows);
        return r;
    endfunction

    function automatic t_in build_op(logic [FUNC_W-1:0] f, int r, int c, logic er);
        t_in op;
        op.func = f;
        op.row = ROW_W'(r);
        op.column = COL_W'(c);
        op.erase = er;
        op.note_value = BYTE_W'($urandom);
        op.instrument_value = BYTE_W'($urandom);
        op.volume_value = BYTE_W'($urandom);
        op.command_value = BYTE_W'($urandom);
        op.argument_value = BYTE_W'($urandom);
        return op;
    endfunction

    function automatic t_in random_op();
        t_in op;
        int pick, key, r;
        logic [FUNC_W-1:0] f;
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            op = build_op(FN_CLEAR, $urandom_range(0, 511), $urandom_range(0, 63),
                          1'($urandom_range(0, 1)));
        end else if (pick < 10) begin
            r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(24, 256);
            op = build_op(FN_SETLEN, r, $urandom_range(0, 63), 1'($urandom_range(0, 1)));
        end else begin
            f = (pick < 50) ? FN_READ : FN_WRITE;
            if (recent_cells.size() > 0 && $urandom_range(0, 99) < 55) begin
                key = recent_cells[$urandom_range(0, recent_cells.size() - 1)];
            end else if ($urandom_range(0, 19) == 0) begin
                key = $urandom_range(0, 512 * COLUMNS - 1);
            end else begin
                key = $urandom_range(0, DEFAULT_ROWS * COLUMNS - 1);
            end
            op = build_op(f, key / COLUMNS, key % COLUMNS, $urandom_range(0, 3) == 0);
            if (f == FN_WRITE && !op.erase) begin
                recent_cells.push_back(key);
                if (recent_cells.size() > 48) begin
                    void'(recent_cells.pop_front());
                end
            end
        end
        return op;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) begin
            return 0;
        end
        if (p < 85) begin
            return $urandom_range(1, 8);
        end
        if (p < 95) begin
            return $urandom_range(9, 200);
        end
        return $urandom_range(201, 1500);
    endfunction

    // Sender: bursts of transfers separated by random gaps.
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) begin
                expected_q.push_back(apply_cell_op(i_in_data));
            end
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (op_queue.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_data <= op_queue.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = pick_gap();
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: switches between stall patterns, with long hold-offs now and then.
    int hold_left = 0;
    int mode_left = 0;
    int stall_mode = 0;
    int rx_phase = 0;
    logic next_ready;
    logic bad_field;
    t_out want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("unexpected result: %p", o_out_data);
                    end
                end else begin
                    want = expected_q.pop_front();
                    bad_field = o_out_data.status !== want.status
                        || o_out_data.found !== want.found
                        || o_out_data.note_out !== want.note_out
                        || o_out_data.instrument_out !== want.instrument_out
                        || o_out_data.volume_out !== want.volume_out
                        || o_out_data.command_out !== want.command_out
                        || o_out_data.argument_out !== want.argument_out
                        || o_out_data.entries_used !== want.entries_used
                        || o_out_data.rows_now !== want.rows_now;
                    if (bad_field) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("mismatch on result %0d: expected %p", results_seen, want);
                            $display("    got %p", o_out_data);
                        end
                    end
                end
                if (results_seen == 30 || results_seen == 250 || results_seen == 500) begin
                    hold_left = HOLD_OFF_CYCLES;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(50, 2000);
                end else begin
                    mode_left--;
                end
                rx_phase++;
                case (stall_mode)
                    0: next_ready = 1'b1;
                    1: next_ready = (rx_phase % 5) >= 2;
                    default: next_ready = $urandom_range(0, 3) != 0;
                endcase
            end
            i_out_ready <= next_ready;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        t_in op;
        int k, key;

        // Directed part: field extremes, every operation and the corner cases.
        op_queue.push_back(build_op(FN_READ, 0, 0, 1'b0));
        op = build_op(FN_WRITE, 0, 0, 1'b0);
        {op.note_value, op.instrument_value, op.volume_value,
         op.command_value, op.argument_value} = '1;
        op_queue.push_back(op);
        op = build_op(FN_WRITE, 63, 63, 1'b0);
        {op.note_value, op.instrument_value, op.volume_value,
         op.command_value, op.argument_value} = '0;
        op_queue.push_back(op);
        op_queue.push_back(build_op(FN_READ, 0, 0, 1'b1));
        op_queue.push_back(build_op(FN_READ, 63, 63, 1'b0));
        op_queue.push_back(build_op(FN_WRITE, 10, 5, 1'b0));
        op_queue.push_back(build_op(FN_WRITE, 10, 5, 1'b0));
        op_queue.push_back(build_op(FN_READ, 10, 5, 1'b0));
        op_queue.push_back(build_op(FN_READ, 64, 63, 1'b0));
        op_queue.push_back(build_op(FN_WRITE, 511, 0, 1'b0));
        op_queue.push_back(build_op(FN_WRITE, 1, 1, 1'b1));
        op_queue.push_back(build_op(FN_WRITE, 10, 5, 1'b1));
        op_queue.push_back(build_op(FN_SETLEN, 0, 0, 1'b0));
        op_queue.push_back(build_op(FN_SETLEN, 257, 0, 1'b0));
        op_queue.push_back(build_op(FN_SETLEN, 511, 63, 1'b1));
        op_queue.push_back(build_op(FN_SETLEN, 256, 0, 1'b0));
        op_queue.push_back(build_op(FN_WRITE, 255, 63, 1'b0));
        op_queue.push_back(build_op(FN_READ, 255, 63, 1'b0));
        op_queue.push_back(build_op(FN_SETLEN, 32, 0, 1'b0));
        op_queue.push_back(build_op(FN_READ, 63, 63, 1'b0));
        op_queue.push_back(build_op(FN_SETLEN, 1, 0, 1'b0));
        op_queue.push_back(build_op(FN_WRITE, 0, 7, 1'b0));
        op_queue.push_back(build_op(FN_CLEAR, 511, 63, 1'b1));
        op_queue.push_back(build_op(FN_READ, 0, 0, 1'b0));

        // A few scattered cells: erase of missing cells, insert and read back.
        op_queue.push_back(build_op(FN_WRITE, 0, 0, 1'b0));
        key = (1030 * 2731) % (DEFAULT_ROWS * COLUMNS);
        op_queue.push_back(build_op(FN_WRITE, key / COLUMNS, key % COLUMNS, 1'b1));
        key = (5 * 2731) % (DEFAULT_ROWS * COLUMNS);
        op_queue.push_back(build_op(FN_WRITE, key / COLUMNS, key % COLUMNS, 1'b1));
        key = (2000 * 2731) % (DEFAULT_ROWS * COLUMNS);
        op_queue.push_back(build_op(FN_WRITE, key / COLUMNS, key % COLUMNS, 1'b0));
        op_queue.push_back(build_op(FN_READ, key / COLUMNS, key % COLUMNS, 1'b0));
        key = (2001 * 2731) % (DEFAULT_ROWS * COLUMNS);
        op_queue.push_back(build_op(FN_WRITE, key / COLUMNS, key % COLUMNS, 1'b0));

        for (k = 0; k < RANDOM_OPS; k++) begin
            op_queue.push_back(random_op());
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_queue.size() != 0 || i_in_valid || expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[filelist.f]
src/ssc_pkg.sv
src/ssc_cell.sv
src/sparse_sorted_cell_store.sv
src/ssc_checker.sv
bench/tb_sparse_sorted_cell_store.sv
